[rtl/core/ipd_pkg.sv]
// package for the indexed point distance block
// holds request codes, widths and shared types; no dependencies
`timescale 1ns / 1ps

package ipd_pkg;

  localparam int CoordW = 24;
  localparam int MagW   = 24;
  localparam int SqW    = 48;
  localparam int SumW   = 50;
  localparam int DistW  = 25;
  localparam int RootSteps = 25;

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic {
    METRIC_EUCLID = 1'b0,
    METRIC_CHEBY  = 1'b1
  } metric_t;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

endpackage

[rtl/core/ipd_root.sv]
// pipelined integer square root, one result bit per stage
// depends on ipd_pkg for widths
`timescale 1ns / 1ps

module ipd_root (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [ipd_pkg::SumW-1:0]   radicand,
  input  logic                       in_cheby,
  input  logic [ipd_pkg::DistW-1:0]  cheby_dist,
  output logic                       out_valid,
  output logic [ipd_pkg::DistW-1:0]  out_dist
);
  import ipd_pkg::*;

  localparam int RemW = DistW + 2;

  // per stage: remaining radicand bits, partial root, remainder, bypass
  logic [RootSteps:0]             vld;
  logic [SumW-1:0]                rad  [RootSteps+1];
  logic [DistW-1:0]               root [RootSteps+1];
  logic [RemW-1:0]                rem  [RootSteps+1];
  logic                           chb  [RootSteps+1];
  logic [DistW-1:0]               chd  [RootSteps+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = radicand;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign chb[0]  = in_cheby;
  assign chd[0]  = cheby_dist;

  // restoring digit recurrence, two radicand bits per stage
  for (genvar s = 0; s < RootSteps; s++) begin : g_stage
    logic [RemW-1:0] trial_rem;
    logic [RemW-1:0] trial_sub;
    always_comb begin
      trial_rem = {rem[s][RemW-3:0], rad[s][SumW-1 -: 2]};
      trial_sub = {root[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rad[s+1] <= {rad[s][SumW-3:0], 2'b00};
      chb[s+1] <= chb[s];
      chd[s+1] <= chd[s];
      if (trial_rem >= trial_sub) begin
        rem[s+1]  <= trial_rem - trial_sub;
        root[s+1] <= {root[s][DistW-2:0], 1'b1};
      end else begin
        rem[s+1]  <= trial_rem;
        root[s+1] <= {root[s][DistW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[RootSteps];
  assign out_dist  = chb[RootSteps] ? chd[RootSteps] : root[RootSteps];

endmodule

[rtl/core/indexed_point_distance.sv]
// indexed point distance: two point tables, euclidean or chebyshev distance
// depends on ipd_pkg and ipd_root
`timescale 1ns / 1ps
//
// channel   direction  handshake           payload
// request   in         start, busy         req_type slot coord_x/y/z index_a index_b
// result    out        done (one cycle)    distance
// config    in         cfg_valid/cfg_ready cfg_data (metric)
//
// one request is accepted every cycle; busy is held low.
// an accepted query's distance comes from a table read, difference, square,
// sum, then 25 stages of the square root (one bit each).
// loads give no result. reset clears the metric and all valid bits; tables are
// not cleared. the result cannot be stalled, so the pipeline never stops.

module indexed_point_distance #(
  parameter int POINTS_A = 1024,
  parameter int POINTS_B = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [9:0]                  slot,
  input  logic signed [23:0]          coord_x,
  input  logic signed [23:0]          coord_y,
  input  logic signed [23:0]          coord_z,
  input  logic [9:0]                  index_a,
  input  logic [9:0]                  index_b,
  output logic                        done,
  output logic [ipd_pkg::DistW-1:0]   distance,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);
  import ipd_pkg::*;

  localparam int AW_A = (POINTS_A > 1) ? $clog2(POINTS_A) : 1;
  localparam int AW_B = (POINTS_B > 1) ? $clog2(POINTS_B) : 1;

  logic    metric;
  point_t  mem_a [POINTS_A];
  point_t  mem_b [POINTS_B];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // metric register
  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= METRIC_EUCLID;
    end else if (cfg_valid && cfg_ready) begin
      metric <= cfg_data;
    end
  end

  logic   accept;
  point_t wr_point;
  assign accept   = start && !busy;
  assign wr_point = '{x: coord_x, y: coord_y, z: coord_z};

  // table writes
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_LOAD_A && 32'(slot) < POINTS_A) begin
      mem_a[AW_A'(slot)] <= wr_point;
    end
    if (accept && req_type == REQ_LOAD_B && 32'(slot) < POINTS_B) begin
      mem_b[AW_B'(slot)] <= wr_point;
    end
  end

  // stage 1: registered table reads
  logic   s1_vld, s1_ina, s1_inb;
  point_t s1_a, s1_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept && req_type == REQ_QUERY;
    end
    s1_ina <= 32'(index_a) < POINTS_A;
    s1_inb <= 32'(index_b) < POINTS_B;
    s1_a   <= mem_a[AW_A'(index_a)];
    s1_b   <= mem_b[AW_B'(index_b)];
  end

  // stage 2: absolute differences
  point_t pa, pb;
  assign pa = s1_ina ? s1_a : '0;
  assign pb = s1_inb ? s1_b : '0;

  function automatic logic [MagW-1:0] absdiff(input coord_t a, input coord_t b);
    logic signed [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    return d[CoordW] ? MagW'(-d) : d[MagW-1:0];
  endfunction

  logic            s2_vld, s2_chb;
  logic [MagW-1:0] s2_m [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_chb  <= metric;
    s2_m[0] <= absdiff(pa.x, pb.x);
    s2_m[1] <= absdiff(pa.y, pb.y);
    s2_m[2] <= absdiff(pa.z, pb.z);
  end

  // stage 3: squares and chebyshev maximum of two
  logic            s3_vld, s3_chb;
  logic [SqW-1:0]  s3_sq [3];
  logic [MagW-1:0] s3_mxy, s3_mz;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_chb <= s2_chb;
    for (int k = 0; k < 3; k++) begin
      s3_sq[k] <= s2_m[k] * s2_m[k];
    end
    s3_mxy <= (s2_m[0] > s2_m[1]) ? s2_m[0] : s2_m[1];
    s3_mz  <= s2_m[2];
  end

  // stage 4: sum of squares and final maximum
  logic             s4_vld, s4_chb;
  logic [SumW-1:0]  s4_sum;
  logic [DistW-1:0] s4_cd;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_chb <= s3_chb;
    s4_sum <= SumW'(s3_sq[0]) + SumW'(s3_sq[1]) + SumW'(s3_sq[2]);
    s4_cd  <= DistW'((s3_mz > s3_mxy) ? s3_mz : s3_mxy);
  end

  // square root pipeline carries the chebyshev result alongside
  ipd_root u_root (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s4_vld),
    .radicand   (s4_sum),
    .in_cheby   (s4_chb),
    .cheby_dist (s4_cd),
    .out_valid  (done),
    .out_dist   (distance)
  );

endmodule
